[src/hps_pkg.sv]
`timescale 1ns / 1ps
// shared constants, codes and types of the heap process scheduler
// depends on nothing; every other file but hps_ram imports it
package hps_pkg;

	// sizing
	localparam int CAPACITY      = 1024;
	localparam int PRIORITY_BITS = 16;
	localparam int TIME_BITS     = 16;

	// elapsed time may pass the required time by up to one priority
	localparam int ELAPSED_W = ((PRIORITY_BITS > TIME_BITS) ? PRIORITY_BITS : TIME_BITS) + 1;
	localparam int KEY_W     = PRIORITY_BITS + ELAPSED_W;
	localparam int IDX_W     = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int SWITCH_W  = 32;
	localparam int STATUS_W  = 2;

	// operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_STEP   = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_ZERO_PRI = 2'd3;

	// input transaction payload
	typedef struct packed {
		logic                     op;
		logic [PRIORITY_BITS-1:0] priority_req;
		logic [TIME_BITS-1:0]     required_time;
	} hps_in_t;

	// result transaction payload
	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic [PRIORITY_BITS-1:0] served_priority;
		logic [ELAPSED_W-1:0]     served_elapsed;
		logic                     finished;
		logic [SWITCH_W-1:0]      switch_count;
		logic [CNT_W-1:0]         occupancy;
	} hps_out_t;

	// one heap slot, the key is kept next to the process to avoid re-multiplying
	typedef struct packed {
		logic [KEY_W-1:0]         key;
		logic [PRIORITY_BITS-1:0] pri;
		logic [ELAPSED_W-1:0]     elapsed;
		logic [TIME_BITS-1:0]     need;
	} hps_entry_t;

	localparam int ENTRY_W = $bits(hps_entry_t);

	// heap memory access request from the sequencer
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		hps_entry_t       wdata;
		logic [IDX_W-1:0] raddr_a;
		logic [IDX_W-1:0] raddr_b;
	} hps_ram_req_t;

endpackage

[src/hps_in_if.sv]
`timescale 1ns / 1ps
// valid/ready channel carrying scheduler requests
// depends on hps_pkg
interface hps_in_if import hps_pkg::*; ();

	logic    valid;
	logic    ready;
	hps_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

[src/hps_out_if.sv]
`timescale 1ns / 1ps
// valid/ready channel carrying scheduler results
// depends on hps_pkg
interface hps_out_if import hps_pkg::*; ();

	logic     valid;
	logic     ready;
	hps_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

[src/hps_ram.sv]
`timescale 1ns / 1ps
// generic ram: one write port, two read ports with registered read data
// no dependencies
module hps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read ports
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

[src/hps_core.sv]
`timescale 1ns / 1ps
// heap sequencer: insert with sift-up, extract-min with sift-down, reinsertion
// depends on hps_pkg; drives the heap memory through an hps_ram_req_t
module hps_core import hps_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  hps_in_t      in_data,
	output logic         in_ready,
	output logic         res_valid,
	output hps_out_t     res_data,
	input  logic         res_ready,
	output hps_ram_req_t ram_req,
	input  hps_entry_t   rd_a,
	input  hps_entry_t   rd_b
);

	localparam int IX_W = IDX_W + 2;
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_POP   = 3'd1;
	localparam logic [2:0] S_SINK  = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_REINS = 3'd4;
	localparam logic [2:0] S_LIFT  = 3'd5;
	localparam logic [2:0] S_PLACE = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	function automatic logic [IDX_W-1:0] parent_of(input logic [IDX_W-1:0] i);
		return (i - IDX_W'(1)) >> 1;
	endfunction

	logic [2:0]               state_q;
	logic [CNT_W-1:0]         count_q;
	logic [SWITCH_W-1:0]      switch_q;
	logic [IDX_W-1:0]         idx_q;
	hps_entry_t               mov_q;
	logic [PRIORITY_BITS-1:0] cur_pri_q;
	logic [ELAPSED_W-1:0]     cur_el_q;
	logic [TIME_BITS-1:0]     cur_need_q;
	logic [KEY_W-1:0]         prod_q;
	logic [STATUS_W-1:0]      status_q;
	logic [PRIORITY_BITS-1:0] spri_q;
	logic [ELAPSED_W-1:0]     sel_q;
	logic                     fin_q;

	logic [IX_W-1:0]  cnt_ext;
	logic [IX_W-1:0]  left_ix;
	logic [IX_W-1:0]  right_ix;
	logic             left_ok;
	logic             right_ok;
	logic             take_l;
	logic             take_r;
	logic [IDX_W-1:0] best_idx;
	logic [IX_W-1:0]  best_l_ix;
	logic [IX_W-1:0]  best_r_ix;
	logic [IDX_W-1:0] idx_par;
	logic [IDX_W-1:0] cnt_idx;
	logic [CNT_W-1:0] cnt_dec;
	logic [IDX_W-1:0] cnt_par;
	logic [ELAPSED_W-1:0] el_inc;
	logic             lift_less;

	// child selection for the sift-down, read data arrives in the cycle after the address
	assign cnt_ext   = IX_W'(count_q);
	assign left_ix   = {1'b0, idx_q, 1'b1};
	assign right_ix  = left_ix + IX_W'(1);
	assign left_ok   = left_ix < cnt_ext;
	assign right_ok  = right_ix < cnt_ext;
	assign take_l    = left_ok && (rd_a.key < mov_q.key);
	assign take_r    = right_ok && (take_l ? (rd_b.key < rd_a.key) : (rd_b.key < mov_q.key));
	assign best_idx  = take_r ? right_ix[IDX_W-1:0] : left_ix[IDX_W-1:0];
	assign best_l_ix = {1'b0, best_idx, 1'b1};
	assign best_r_ix = best_l_ix + IX_W'(1);

	// sift-up and slot indexes
	assign idx_par   = parent_of(idx_q);
	assign cnt_idx   = count_q[IDX_W-1:0];
	assign cnt_dec   = count_q - CNT_W'(1);
	assign cnt_par   = parent_of(cnt_idx);
	assign lift_less = mov_q.key < rd_a.key;
	assign el_inc    = cur_el_q + ELAPSED_W'(1);

	// heap memory requests
	always_comb begin
		ram_req.we      = 1'b0;
		ram_req.waddr   = idx_q;
		ram_req.wdata   = mov_q;
		ram_req.raddr_a = '0;
		ram_req.raddr_b = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_data.op == OP_STEP) begin
					ram_req.raddr_b = cnt_dec[IDX_W-1:0];
				end else begin
					ram_req.raddr_a = cnt_par;
				end
			end
			S_POP: begin
				ram_req.raddr_a = IDX_W'(1);
				ram_req.raddr_b = IDX_W'(2);
			end
			S_SINK: begin
				ram_req.we = 1'b1;
				if (take_r) begin
					ram_req.wdata = rd_b;
				end else if (take_l) begin
					ram_req.wdata = rd_a;
				end
				ram_req.raddr_a = best_l_ix[IDX_W-1:0];
				ram_req.raddr_b = best_r_ix[IDX_W-1:0];
			end
			S_REINS: begin
				ram_req.raddr_a = cnt_par;
			end
			S_LIFT: begin
				ram_req.we = 1'b1;
				if (lift_less) begin
					ram_req.wdata = rd_a;
				end
				ram_req.raddr_a = parent_of(idx_par);
			end
			S_PLACE: begin
				ram_req.we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// key of the process going back in, registered after the multiplier
	always_ff @(posedge clk) begin
		prod_q <= KEY_W'(cur_pri_q) * KEY_W'(el_inc);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			switch_q   <= '0;
			idx_q      <= '0;
			mov_q      <= '0;
			cur_pri_q  <= '0;
			cur_el_q   <= '0;
			cur_need_q <= '0;
			status_q   <= ST_OK;
			spri_q     <= '0;
			sel_q      <= '0;
			fin_q      <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						status_q <= ST_OK;
						spri_q   <= '0;
						sel_q    <= '0;
						fin_q    <= 1'b0;
						if (in_data.op == OP_INSERT) begin
							if (in_data.priority_req == '0) begin
								status_q <= ST_ZERO_PRI;
								state_q  <= S_DONE;
							end else if (count_q == CNT_FULL) begin
								status_q <= ST_FULL;
								state_q  <= S_DONE;
							end else begin
								mov_q.key     <= KEY_W'(in_data.priority_req);
								mov_q.pri     <= in_data.priority_req;
								mov_q.elapsed <= '0;
								mov_q.need    <= in_data.required_time;
								idx_q         <= cnt_idx;
								count_q       <= count_q + CNT_W'(1);
								state_q       <= (count_q == '0) ? S_PLACE : S_LIFT;
							end
						end else if (count_q == '0) begin
							status_q <= ST_EMPTY;
							state_q  <= S_DONE;
						end else begin
							count_q <= cnt_dec;
							state_q <= S_POP;
						end
					end
				end
				S_POP: begin
					cur_pri_q  <= rd_a.pri;
					cur_el_q   <= rd_a.elapsed + ELAPSED_W'(rd_a.pri);
					cur_need_q <= rd_a.need;
					if (switch_q != '1) begin
						switch_q <= switch_q + SWITCH_W'(1);
					end
					mov_q   <= rd_b;
					idx_q   <= '0;
					state_q <= (count_q != '0) ? S_SINK : S_MUL;
				end
				S_SINK: begin
					if (take_l || take_r) begin
						idx_q <= best_idx;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_REINS;
				end
				S_REINS: begin
					spri_q <= cur_pri_q;
					sel_q  <= cur_el_q;
					if (cur_el_q < ELAPSED_W'(cur_need_q)) begin
						mov_q.key     <= prod_q;
						mov_q.pri     <= cur_pri_q;
						mov_q.elapsed <= cur_el_q;
						mov_q.need    <= cur_need_q;
						idx_q         <= cnt_idx;
						count_q       <= count_q + CNT_W'(1);
						state_q       <= (count_q == '0) ? S_PLACE : S_LIFT;
					end else begin
						fin_q   <= 1'b1;
						state_q <= S_DONE;
					end
				end
				S_LIFT: begin
					if (lift_less) begin
						idx_q <= idx_par;
						if (idx_par == '0) begin
							state_q <= S_PLACE;
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				S_PLACE: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// handshake and result
	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	always_comb begin
		res_data.status          = status_q;
		res_data.served_priority = spri_q;
		res_data.served_elapsed  = sel_q;
		res_data.finished        = fin_q;
		res_data.switch_count    = switch_q;
		res_data.occupancy       = count_q;
	end

endmodule

[src/heap_process_scheduler.sv]
`timescale 1ns / 1ps
// heap process scheduler: min-heap of processes keyed by priority * (elapsed + 1)
// results leave the sequencer through an output register
// one transaction in flight; the next is taken as soon as the sequencer returns to idle
// rate is set by the heap walk through the memory, one tree level per cycle in each direction
// reset clears the process count and switch total; heap memory is not cleared
// depends on hps_pkg, hps_in_if, hps_out_if, hps_ram and hps_core
module heap_process_scheduler import hps_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	hps_in_if.sink    req,
	hps_out_if.source rsp
);

	hps_ram_req_t ram_req;
	hps_entry_t   rd_a;
	hps_entry_t   rd_b;
	logic         core_ready;
	logic         res_valid;
	hps_out_t     res_data;
	logic         res_ready;
	logic         out_valid_q;
	hps_out_t     out_data_q;

	// heap storage
	hps_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk    (clk),
		.we     (ram_req.we),
		.waddr  (ram_req.waddr),
		.wdata  (ram_req.wdata),
		.raddr_a(ram_req.raddr_a),
		.raddr_b(ram_req.raddr_b),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	// heap sequencer
	hps_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_data  (req.data),
		.in_ready (core_ready),
		.res_valid(res_valid),
		.res_data (res_data),
		.res_ready(res_ready),
		.ram_req  (ram_req),
		.rd_a     (rd_a),
		.rd_b     (rd_b)
	);

	assign req.ready = core_ready;

	// output register
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
			out_data_q  <= res_data;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_data_q;

endmodule

[src/hps_checker.sv]
`timescale 1ns / 1ps
// port-level checks of the heap process scheduler results, bound to the top level
// depends on hps_pkg and heap_process_scheduler
module hps_checker import hps_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input hps_out_t rsp_data
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	// full and empty reports match the occupancy
	a_occ_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |->
		((rsp_data.status != ST_FULL) || (rsp_data.occupancy == CNT_W'(CAPACITY))) &&
		((rsp_data.status != ST_EMPTY) || (rsp_data.occupancy == '0)))
		else $error("occupancy does not match full or empty status");

	// an error transaction serves no process
	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.status != ST_OK) |->
		(rsp_data.served_priority == '0) && (rsp_data.served_elapsed == '0) &&
		!rsp_data.finished)
		else $error("error transaction reports a served process");

	// occupancy never exceeds capacity
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.occupancy <= CNT_W'(CAPACITY))
		else $error("occupancy above capacity");

endmodule

bind heap_process_scheduler hps_checker u_hps_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_data (rsp.data)
);
